### sv/fifo_edf_wait_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wait list block
// Implication checks, same cycle and next cycle, clocked and resettable.
// ----------------------------------------------------------------------------
`ifndef FIFO_EDF_WAIT_LIST_ASSERT_SVH
`define FIFO_EDF_WAIT_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
`define FEWL_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("wait list assertion failed");
`define FEWL_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("wait list assertion failed");
`else
`define FEWL_ASSERT_IMP(label, clk, rst, pre, post)
`define FEWL_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

### sv/fewl_pkg.sv
// ----------------------------------------------------------------------------
// fewl_pkg
// Shared widths, operation codes, entry layout and controller interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fewl_pkg;

   localparam int NUM_RESOURCES_DEF = 16;
   localparam int MAX_WAITERS_DEF   = 2;

   localparam int OP_W   = 2;
   localparam int RES_W  = 4;
   localparam int REQ_W  = 8;
   localparam int TIME_W = 32;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] arrival;
      logic [REQ_W-1:0]  requester;
   } entry_type;

   typedef struct packed {
      logic load;
      logic count;
      logic scan;
      logic add_wr;
      logic shift_wr;
      logic cnt_dec;
      logic clear;
      logic turn_ld;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic            clear_done;
      logic            res_ok;
      logic [OP_W-1:0] op;
      logic            n_zero;
      logic            n_full;
      logic            last;
      logic            match;
      logic            found;
      logic            rsp_free;
   } status_type;

   function automatic logic beats(logic mode, entry_type a, entry_type b);
      logic result;
      if (!mode) begin
         result = a.arrival < b.arrival;
      end else if (a.deadline != b.deadline) begin
         result = a.deadline < b.deadline;
      end else begin
         result = a.arrival < b.arrival;
      end
      return result;
   endfunction

endpackage

### sv/fewl_ram.sv
// ----------------------------------------------------------------------------
// fewl_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fewl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/fewl_ctrl.sv
// ----------------------------------------------------------------------------
// fewl_ctrl
// Sequencer: clearing pass, accept, count lookup, list scan, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fewl_ctrl import fewl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_COUNT = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            if (!status.res_ok || status.op == OP_NONE) begin
               state_in = ST_DONE;
            end else if (status.op == OP_ADD) begin
               cmd.add_wr = !status.n_full;
               state_in   = ST_DONE;
            end else if (status.n_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.op == OP_REMOVE) begin
               cmd.shift_wr = status.found;
               cmd.cnt_dec  = status.last && (status.found || status.match);
            end else begin
               cmd.turn_ld = status.last;
            end
            if (status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/fewl_datapath.sv
// ----------------------------------------------------------------------------
// fewl_datapath
// Count and entry memories, item registers, best-waiter tracking, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fewl_datapath import fewl_pkg::*; #(
   parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
   parameter int MAX_WAITERS   = MAX_WAITERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [OP_W-1:0]   req_op,
   input  logic [RES_W-1:0]  req_res,
   input  logic [REQ_W-1:0]  req_who,
   input  logic [TIME_W-1:0] req_arr,
   input  logic [TIME_W-1:0] req_dl,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              rsp_tready,
   output status_type        status,
   output logic              rsp_tvalid,
   output logic              rsp_is_turn
);

   localparam int SLOTS = NUM_RESOURCES * MAX_WAITERS;
   localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int CW    = $clog2(MAX_WAITERS + 1);
   localparam int IW    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int XW    = RW + CW + 1;

   function automatic logic [RW-1:0] res_addr(logic [RES_W-1:0] r);
      logic [RW+RES_W-1:0] wide;
      wide = (RW + RES_W)'(r);
      return wide[RW-1:0];
   endfunction

   function automatic logic [SW-1:0] slot(logic [RW-1:0] r, logic [XW-1:0] off);
      logic [XW-1:0] sum;
      sum = XW'(r) * XW'(MAX_WAITERS) + off;
      return sum[SW-1:0];
   endfunction

   logic              policy_ff;
   logic [OP_W-1:0]   op_ff;
   logic [RES_W-1:0]  res_ff;
   logic [REQ_W-1:0]  who_ff;
   logic [TIME_W-1:0] arr_ff;
   logic [TIME_W-1:0] dl_ff;
   logic [CW-1:0]     n_ff;
   logic [IW-1:0]     idx_ff;
   logic              found_ff;
   entry_type         best_ff;
   logic              turn_ff;
   logic [RW-1:0]     clr_ff;
   logic              rsp_valid_ff;
   logic              rsp_turn_ff;

   logic [CW-1:0]     cnt_rd;
   logic              cnt_we;
   logic [RW-1:0]     cnt_waddr;
   logic [CW-1:0]     cnt_wdata;
   entry_type         ent_rd;
   entry_type         ent_wdata;
   logic              ent_we;
   logic [SW-1:0]     ent_waddr;
   logic [SW-1:0]     ent_raddr;
   logic [XW-1:0]     idx_next;
   entry_type         winner;

   assign idx_next = XW'(idx_ff) + XW'(1);
   assign winner   = (idx_ff == '0 || beats(policy_ff, ent_rd, best_ff)) ? ent_rd : best_ff;

   always_comb begin
      cnt_we    = cmd.clear | cmd.add_wr | cmd.cnt_dec;
      cnt_waddr = cmd.clear ? clr_ff : res_addr(res_ff);
      if (cmd.clear) begin
         cnt_wdata = '0;
      end else if (cmd.add_wr) begin
         cnt_wdata = cnt_rd + CW'(1);
      end else begin
         cnt_wdata = n_ff - CW'(1);
      end
      ent_we = cmd.add_wr | cmd.shift_wr;
      if (cmd.add_wr) begin
         ent_waddr = slot(res_addr(res_ff), XW'(cnt_rd));
         ent_wdata = '{deadline: dl_ff, arrival: arr_ff, requester: who_ff};
      end else begin
         ent_waddr = slot(res_addr(res_ff), XW'(idx_ff) - XW'(1));
         ent_wdata = ent_rd;
      end
      ent_raddr = slot(res_addr(res_ff), cmd.scan ? idx_next : '0);
   end

   fewl_ram #(
      .WIDTH (CW),
      .DEPTH (NUM_RESOURCES)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (res_addr(req_res)),
      .rdata (cnt_rd)
   );

   fewl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         res_ff <= req_res;
         who_ff <= req_who;
         arr_ff <= req_arr;
         dl_ff  <= req_dl;
      end
      if (cmd.count) begin
         n_ff     <= cnt_rd;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff   <= idx_next[IW-1:0];
         best_ff  <= winner;
         found_ff <= found_ff | status.match;
      end
      if (cmd.load) begin
         turn_ff <= 1'b0;
      end else if (cmd.turn_ld) begin
         turn_ff <= (winner.requester == who_ff);
      end
      if (cmd.rsp_load) begin
         rsp_turn_ff <= turn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            policy_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + RW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.clear_done = (clr_ff == RW'(NUM_RESOURCES - 1));
      status.res_ok     = ({28'd0, res_ff} < 32'(NUM_RESOURCES));
      status.op         = op_ff;
      status.n_zero     = (cnt_rd == '0);
      status.n_full     = (XW'(cnt_rd) >= XW'(MAX_WAITERS));
      status.last       = (idx_next == XW'(n_ff));
      status.match      = (ent_rd.requester == who_ff);
      status.found      = found_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_is_turn = rsp_turn_ff;

endmodule

### sv/fifo_edf_wait_list.sv
// ----------------------------------------------------------------------------
// fifo_edf_wait_list
// Flow: an add, bad index or unused code goes from accept through count lookup
// to the result word; a remove or query on n waiters also scans the list, one entry a cycle.
// One word in flight; the next is taken only once the result is queued.
// Reset: synchronous; a clearing pass over all NUM_RESOURCES entries zeroes the
// count memory, with the input held off. Policy resets to oldest arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_edf_wait_list_assert.svh"

module fifo_edf_wait_list import fewl_pkg::*; #(
   parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
   parameter int MAX_WAITERS   = MAX_WAITERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // tuser: operation[1:0]
   // tdata: resource_index[3:0], requester_id[11:4], arrival_time[43:12],
   //        deadline_time[75:44], zero fill [79:76]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [79:0] req_tdata,
   // tdata: is_turn[0], zero fill [7:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       is_turn;

   fewl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   fewl_datapath #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .MAX_WAITERS   (MAX_WAITERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_op      (req_tuser),
      .req_res     (req_tdata[3:0]),
      .req_who     (req_tdata[11:4]),
      .req_arr     (req_tdata[43:12]),
      .req_dl      (req_tdata[75:44]),
      .csr_we      (csr_valid & csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_is_turn (is_turn)
   );

   assign rsp_tdata = {7'd0, is_turn};
   assign csr_ready = 1'b1;

   `FEWL_ASSERT_NXT(a_one_word_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `FEWL_ASSERT_IMP(a_clear_holds_input, clock, reset, $fell(reset), !req_tready)

endmodule
